FILE: design/rtm_pkg.sv
`default_nettype none

package rtm_pkg;

  // Default sizes for the top-level parameters.
  localparam int MAX_DIM_DEF    = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int ACC_WIDTH_DEF  = 48;

  // Fixed sizes that follow from the item fields.
  localparam int MAX_OUT   = 16;
  localparam int FRAC_BITS = 16;
  localparam int COL_W     = 4;
  localparam int TAG_W     = 16;
  localparam int ELEM_W    = 32;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLUMNS  = 1'd1;

  // Item opcodes.
  localparam logic OP_LOAD_B   = 1'b0;
  localparam logic OP_ROW_ELEM = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // Column tag that travels with a term through the multiply pipeline.
  typedef struct packed {
    logic             vld;
    logic [COL_W-1:0] col;
  } tag_t;

endpackage

`default_nettype wire

FILE: design/rtm_in_if.sv
`default_nettype none

interface rtm_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [rtm_pkg::COL_W-1:0]         inner_index;
  logic [rtm_pkg::COL_W-1:0]         column_index;
  logic [rtm_pkg::TAG_W-1:0]         row_tag;
  logic signed [rtm_pkg::ELEM_W-1:0] element_value;

  modport source (
    output valid, opcode, inner_index, column_index, row_tag, element_value,
    input  ready
  );

  modport sink (
    input  valid, opcode, inner_index, column_index, row_tag, element_value,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/rtm_out_if.sv
`default_nettype none

interface rtm_out_if;
  logic                              valid;
  logic                              ready;
  logic [rtm_pkg::TAG_W-1:0]         result_row;
  logic [rtm_pkg::COL_W-1:0]         result_column;
  logic signed [rtm_pkg::ELEM_W-1:0] dot_product;
  logic                              last_of_row;

  modport source (
    output valid, result_row, result_column, dot_product, last_of_row,
    input  ready
  );

  modport sink (
    input  valid, result_row, result_column, dot_product, last_of_row,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/rtm_mac_unit.sv
`default_nettype none

module rtm_mac_unit #(
  parameter int DATA_WIDTH = rtm_pkg::DATA_WIDTH_DEF,
  parameter int ACC_WIDTH  = rtm_pkg::ACC_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [DATA_WIDTH-1:0] a_val,
  input  wire logic [DATA_WIDTH-1:0] b_val,
  input  wire rtm_pkg::tag_t         in_tag,
  output rtm_pkg::tag_t              out_tag,
  output logic [ACC_WIDTH-1:0]       term,
  output logic                       busy
);

  localparam int PW = 2 * DATA_WIDTH;
  localparam int SW = ((PW > ACC_WIDTH) ? PW : ACC_WIDTH) + 1;
  localparam logic signed [SW-1:0] AMAX =
    $signed({{(SW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}});
  localparam logic signed [SW-1:0] AMIN = ~AMAX;

  logic signed [PW-1:0]      prod;
  rtm_pkg::tag_t             p_tag;
  logic signed [PW-1:0]      shifted;
  logic signed [SW-1:0]      sh_ext;
  logic [ACC_WIDTH-1:0]      term_next;

  // Stage one: the exact product of the two Q16.16 operands.
  always_ff @(posedge clk) begin
    prod <= $signed(a_val) * $signed(b_val);
  end

  // The arithmetic shift rounds toward minus infinity; then clamp to the
  // accumulator range.
  always_comb begin
    shifted = prod >>> rtm_pkg::FRAC_BITS;
    sh_ext  = SW'(shifted);
    if (sh_ext > AMAX) begin
      term_next = AMAX[ACC_WIDTH-1:0];
    end else if (sh_ext < AMIN) begin
      term_next = AMIN[ACC_WIDTH-1:0];
    end else begin
      term_next = sh_ext[ACC_WIDTH-1:0];
    end
  end

  // Stage two: the scaled term, ready to be added into its column.
  always_ff @(posedge clk) begin
    term <= term_next;
  end

  // Column tags follow the data through both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_tag   <= '0;
      out_tag <= '0;
    end else begin
      p_tag   <= in_tag;
      out_tag <= p_tag;
    end
  end

  assign busy = p_tag.vld | out_tag.vld;

endmodule

`default_nettype wire

FILE: design/row_times_matrix_mac.sv
`default_nettype none

// Channel   Dir  Payload
// items     in   opcode, inner_index, column_index, row_tag, element_value
// results   out  result_row, result_column, dot_product, last_of_row
// cfg       in   cfg_wen, cfg_index, cfg_wdata (write only)
//
// A load item is written into the store while idle. A row element starts a pass:
// one multiply-accumulate unit handles one column per cycle, then the
// store read, product and term stages drain. The element that ends a row
// then emits one result per active column through the single output register.
// Reset is synchronous and clears the sequencer, the registers and the sums.
// A stalled result holds in the output register; items wait while busy.
module row_times_matrix_mac #(
  parameter int MAX_DIM    = rtm_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = rtm_pkg::DATA_WIDTH_DEF,
  parameter int ACC_WIDTH  = rtm_pkg::ACC_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  rtm_in_if.sink                               items,
  rtm_out_if.source                            results,
  input  wire logic                            cfg_wen,
  input  wire logic [rtm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rtm_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OUT_CAP = (MAX_DIM < rtm_pkg::MAX_OUT) ? MAX_DIM : rtm_pkg::MAX_OUT;
  localparam int CW      = rtm_pkg::CFG_W;
  localparam int COLW    = rtm_pkg::COL_W;

  rtm_pkg::state_t state, state_next;

  logic [CW-1:0]         inner_length, out_columns;
  logic [CW-1:0]         n_in, n_out;
  logic [CW-1:0]         col_cnt, col_cnt_next;
  logic                  col_last;
  logic [DATA_WIDTH-1:0] a_val;
  logic [COLW-1:0]       row_reg;
  logic [rtm_pkg::TAG_W-1:0] tag_reg;
  logic                  row_ends;

  logic                  in_ready, in_fire, row_ok, load_ok;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] b_store [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;

  rtm_pkg::tag_t         issue, rd_tag, term_tag;
  logic [ACC_WIDTH-1:0]  term;
  logic                  mac_busy;

  logic [ACC_WIDTH-1:0]  acc [rtm_pkg::MAX_OUT];
  logic [COLW-1:0]       acc_idx;
  logic [ACC_WIDTH-1:0]  acc_rd, acc_sum;
  logic [ACC_WIDTH:0]    sum_wide;

  logic [ACC_WIDTH-DATA_WIDTH:0] hi_bits;
  logic signed [DATA_WIDTH-1:0]  d_sat;
  logic                  out_load;
  logic                  out_vld, out_last;
  logic [rtm_pkg::TAG_W-1:0]  out_row;
  logic [COLW-1:0]            out_col;
  logic signed [rtm_pkg::ELEM_W-1:0] out_dot;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      inner_length <= CW'(16);
      out_columns  <= CW'(16);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        rtm_pkg::CFG_INNER_LENGTH: inner_length <= cfg_wdata;
        rtm_pkg::CFG_OUT_COLUMNS:  out_columns  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective lengths: zero acts as one, large values are capped.
  always_comb begin
    n_in = inner_length;
    if (inner_length == '0) begin
      n_in = CW'(1);
    end else if (int'(inner_length) > MAX_DIM) begin
      n_in = CW'(MAX_DIM);
    end
    n_out = out_columns;
    if (out_columns == '0) begin
      n_out = CW'(1);
    end else if (int'(out_columns) > OUT_CAP) begin
      n_out = CW'(OUT_CAP);
    end
  end

  assign in_fire  = items.valid & in_ready;
  assign row_ok   = {1'b0, items.inner_index} < n_in;
  assign load_ok  = (int'(items.inner_index) < MAX_DIM) &&
                    (int'(items.column_index) < MAX_DIM);
  assign col_last = (col_cnt == (n_out - CW'(1)));
  assign out_load = (state == rtm_pkg::ST_EMIT) && (!out_vld || results.ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rtm_pkg::ST_IDLE: begin
        if (in_fire && items.opcode == rtm_pkg::OP_ROW_ELEM && row_ok) begin
          state_next = rtm_pkg::ST_MAC;
        end
      end
      rtm_pkg::ST_MAC: begin
        if (col_last) begin
          state_next = rtm_pkg::ST_DRAIN;
        end
      end
      rtm_pkg::ST_DRAIN: begin
        if (!rd_tag.vld && !mac_busy) begin
          state_next = row_ends ? rtm_pkg::ST_EMIT : rtm_pkg::ST_IDLE;
        end
      end
      rtm_pkg::ST_EMIT: begin
        if (out_load && col_last) begin
          state_next = rtm_pkg::ST_IDLE;
        end
      end
      default: state_next = rtm_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready     = 1'b0;
    mem_re       = 1'b0;
    issue        = '0;
    col_cnt_next = col_cnt;
    unique case (state)
      rtm_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        col_cnt_next = '0;
      end
      rtm_pkg::ST_MAC: begin
        mem_re       = 1'b1;
        issue.vld    = 1'b1;
        issue.col    = col_cnt[COLW-1:0];
        col_cnt_next = col_last ? '0 : col_cnt + CW'(1);
      end
      rtm_pkg::ST_DRAIN: begin
        col_cnt_next = '0;
      end
      rtm_pkg::ST_EMIT: begin
        if (out_load) begin
          col_cnt_next = col_last ? '0 : col_cnt + CW'(1);
        end
      end
      default: ;
    endcase
  end

  assign items.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rtm_pkg::ST_IDLE;
      col_cnt <= '0;
      rd_tag  <= '0;
    end else begin
      state   <= state_next;
      col_cnt <= col_cnt_next;
      rd_tag  <= issue;
    end
  end

  // Capture every accepted item; the row element that starts a pass is the one used.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_val    <= items.element_value[DATA_WIDTH-1:0];
      row_reg  <= items.inner_index;
      tag_reg  <= items.row_tag;
      row_ends <= ({1'b0, items.inner_index} == (n_in - CW'(1)));
    end
  end

  // Matrix B store: loads write while idle, the pass reads one row.
  assign mem_we = in_fire && (items.opcode == rtm_pkg::OP_LOAD_B) && load_ok;
  assign waddr  = AW'(int'(items.inner_index) * MAX_DIM + int'(items.column_index));
  assign raddr  = AW'(int'(row_reg) * MAX_DIM + int'(col_cnt));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      b_store[waddr] <= items.element_value[DATA_WIDTH-1:0];
    end
    if (mem_re) begin
      rd_data <= b_store[raddr];
    end
  end

  rtm_mac_unit #(
    .DATA_WIDTH (DATA_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .a_val   (a_val),
    .b_val   (rd_data),
    .in_tag  (rd_tag),
    .out_tag (term_tag),
    .term    (term),
    .busy    (mac_busy)
  );

  // One accumulator port: the pipeline adds during a pass, the output drains.
  assign acc_idx  = (state == rtm_pkg::ST_EMIT) ? col_cnt[COLW-1:0] : term_tag.col;
  assign acc_rd   = acc[acc_idx];
  assign sum_wide = {acc_rd[ACC_WIDTH-1], acc_rd} + {term[ACC_WIDTH-1], term};

  // Saturating add into the accumulator range.
  always_comb begin
    if (sum_wide[ACC_WIDTH] != sum_wide[ACC_WIDTH-1]) begin
      acc_sum = sum_wide[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH - 1){1'b0}}}
                                    : {1'b0, {(ACC_WIDTH - 1){1'b1}}};
    end else begin
      acc_sum = sum_wide[ACC_WIDTH-1:0];
    end
  end

  // The last result of a row clears every column, active or not, so that
  // partial sums never leak into a later row.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rtm_pkg::MAX_OUT; i++) begin
        acc[i] <= '0;
      end
    end else if (term_tag.vld) begin
      acc[acc_idx] <= acc_sum;
    end else if (out_load) begin
      if (col_last) begin
        for (int i = 0; i < rtm_pkg::MAX_OUT; i++) begin
          acc[i] <= '0;
        end
      end else begin
        acc[acc_idx] <= '0;
      end
    end
  end

  // Saturate the column sum to the data range.
  always_comb begin
    hi_bits = acc_rd[ACC_WIDTH-1:DATA_WIDTH-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      d_sat = acc_rd[DATA_WIDTH-1:0];
    end else begin
      d_sat = acc_rd[ACC_WIDTH-1] ? {1'b1, {(DATA_WIDTH - 1){1'b0}}}
                                  : {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_load) begin
      out_vld <= 1'b1;
    end else if (results.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row  <= tag_reg;
      out_col  <= col_cnt[COLW-1:0];
      out_dot  <= rtm_pkg::ELEM_W'(d_sat);
      out_last <= col_last;
    end
  end

  assign results.valid         = out_vld;
  assign results.result_row    = out_row;
  assign results.result_column = out_col;
  assign results.dot_product   = out_dot;
  assign results.last_of_row   = out_last;

`ifndef SYNTHESIS
  // The column counter stays inside the active columns.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (state == rtm_pkg::ST_MAC || state == rtm_pkg::ST_EMIT) |-> (col_cnt < n_out))
    else $error("column counter beyond active columns");

  // Terms only arrive during a pass, never while results drain.
  a_term_window: assert property (@(posedge clk) disable iff (rst)
    term_tag.vld |-> (state == rtm_pkg::ST_DRAIN || state == rtm_pkg::ST_MAC))
    else $error("accumulator update outside a pass");

  // The last result of a row returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && col_last) |=> (state == rtm_pkg::ST_IDLE && out_last))
    else $error("row did not close after its last result");

  // Store writes and reads never overlap.
  a_mem_port: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("store written and read in one cycle");
`endif

endmodule

`default_nettype wire
